@@ rtl/pidfd_pkg.sv @@
// shared constants, codes and types of the filtered-derivative pid controller
`default_nettype none

package pidfd_pkg;

   // data formats
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int ILIM_W     = 31;
   localparam int DT_W       = 24;
   localparam int DT_FRAC    = 24;
   localparam int ALPHA_W    = 17;
   localparam int ALPHA_FRAC = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;

   // request op codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_KP     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KI     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_KD     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ILIMIT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DT     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_INVDT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ALPHA  = 3'd6;

   // multiplier operand selection
   localparam int SEL_W = 3;
   localparam logic [SEL_W-1:0] MUL_NONE = 3'd0;
   localparam logic [SEL_W-1:0] MUL_KIE  = 3'd1;
   localparam logic [SEL_W-1:0] MUL_RAW  = 3'd2;
   localparam logic [SEL_W-1:0] MUL_IHI  = 3'd3;
   localparam logic [SEL_W-1:0] MUL_FILT = 3'd4;
   localparam logic [SEL_W-1:0] MUL_ILO  = 3'd5;
   localparam logic [SEL_W-1:0] MUL_KD   = 3'd6;
   localparam logic [SEL_W-1:0] MUL_KP   = 3'd7;

   // product post-processing selection
   localparam logic [SEL_W-1:0] POST_NONE   = 3'd0;
   localparam logic [SEL_W-1:0] POST_KIE    = 3'd1;
   localparam logic [SEL_W-1:0] POST_RDIFF  = 3'd2;
   localparam logic [SEL_W-1:0] POST_ACC_HI = 3'd3;
   localparam logic [SEL_W-1:0] POST_FILT   = 3'd4;
   localparam logic [SEL_W-1:0] POST_ACC_LO = 3'd5;
   localparam logic [SEL_W-1:0] POST_DT_INC = 3'd6;
   localparam logic [SEL_W-1:0] POST_PI     = 3'd7;

   // configuration register file contents
   typedef struct packed {
      logic signed [DATA_W-1:0] kp;
      logic signed [DATA_W-1:0] ki;
      logic signed [DATA_W-1:0] kd;
      logic [ILIM_W-1:0]        i_limit;
      logic [DT_W-1:0]          dt;
      logic [DATA_W-1:0]        inv_dt;
      logic [ALPHA_W-1:0]       d_alpha;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic             load;
      logic             clear;
      logic [SEL_W-1:0] mul_sel;
      logic [SEL_W-1:0] post_sel;
      logic             out_load;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/pidfd_if.sv @@
// request, response and register write channel interfaces
`default_nettype none

interface pidfd_req_if;
   import pidfd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] error_in;
   modport source (output valid, op, error_in, input ready);
   modport sink   (input valid, op, error_in, output ready);
endinterface

interface pidfd_rsp_if;
   import pidfd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive;
   logic signed [DATA_W-1:0] p_term;
   logic signed [DATA_W-1:0] i_term;
   logic signed [DATA_W-1:0] d_term;
   modport source (output valid, drive, p_term, i_term, d_term, input ready);
   modport sink   (input valid, drive, p_term, i_term, d_term, output ready);
endinterface

interface pidfd_csr_if;
   import pidfd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [DATA_W-1:0]     wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/pidfd_csr.sv @@
// configuration register file with write channel
`default_nettype none

module pidfd_csr (
   input  logic                clock,
   input  logic                reset,
   pidfd_csr_if.sink           csr_ch,
   output pidfd_pkg::cfg_type  cfg
);
   import pidfd_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic               wr_en;
   logic [ALPHA_W-1:0] alpha_wr;

   // writes are always taken
   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;
   assign alpha_wr     = csr_ch.wdata[ALPHA_W-1:0];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_ch.addr)
            REG_KP:     cfg_in.kp      = csr_ch.wdata;
            REG_KI:     cfg_in.ki      = csr_ch.wdata;
            REG_KD:     cfg_in.kd      = csr_ch.wdata;
            REG_ILIMIT: cfg_in.i_limit = csr_ch.wdata[ILIM_W-1:0];
            REG_DT:     cfg_in.dt      = csr_ch.wdata[DT_W-1:0];
            REG_INVDT:  cfg_in.inv_dt  = csr_ch.wdata;
            // filter factor saturates at one
            REG_ALPHA:  cfg_in.d_alpha = (alpha_wr > ALPHA_ONE) ? ALPHA_ONE : alpha_wr;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp      <= '0;
         cfg_ff.ki      <= '0;
         cfg_ff.kd      <= '0;
         cfg_ff.i_limit <= '1;
         cfg_ff.dt      <= '0;
         cfg_ff.inv_dt  <= '0;
         cfg_ff.d_alpha <= ALPHA_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/pidfd_ctrl.sv @@
// sequencer that steps the shared multiplier through one update
`default_nettype none

module pidfd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pidfd_pkg::cmd_type cmd
);
   import pidfd_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_KIE  = 4'd1;
   localparam logic [ST_W-1:0] S_RAW  = 4'd2;
   localparam logic [ST_W-1:0] S_IHI  = 4'd3;
   localparam logic [ST_W-1:0] S_FILT = 4'd4;
   localparam logic [ST_W-1:0] S_ILO  = 4'd5;
   localparam logic [ST_W-1:0] S_KD   = 4'd6;
   localparam logic [ST_W-1:0] S_KP   = 4'd7;
   localparam logic [ST_W-1:0] S_PI   = 4'd8;
   localparam logic [ST_W-1:0] S_OUT  = 4'd9;

   logic [ST_W-1:0] state_ff;
   logic [ST_W-1:0] state_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            out_free;

   // result register can take a new result
   assign out_free = !rsp_valid_ff || rsp_ready;

   // step sequence and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.clear    = 1'b0;
      cmd.mul_sel  = MUL_NONE;
      cmd.post_sel = POST_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_KIE;
               end
            end
         end
         S_KIE: begin
            cmd.mul_sel = MUL_KIE;
            state_in    = S_RAW;
         end
         S_RAW: begin
            cmd.mul_sel  = MUL_RAW;
            cmd.post_sel = POST_KIE;
            state_in     = S_IHI;
         end
         S_IHI: begin
            cmd.mul_sel  = MUL_IHI;
            cmd.post_sel = POST_RDIFF;
            state_in     = S_FILT;
         end
         S_FILT: begin
            cmd.mul_sel  = MUL_FILT;
            cmd.post_sel = POST_ACC_HI;
            state_in     = S_ILO;
         end
         S_ILO: begin
            cmd.mul_sel  = MUL_ILO;
            cmd.post_sel = POST_FILT;
            state_in     = S_KD;
         end
         S_KD: begin
            cmd.mul_sel  = MUL_KD;
            cmd.post_sel = POST_ACC_LO;
            state_in     = S_KP;
         end
         S_KP: begin
            cmd.mul_sel  = MUL_KP;
            cmd.post_sel = POST_DT_INC;
            state_in     = S_PI;
         end
         S_PI: begin
            cmd.post_sel = POST_PI;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/pidfd_dp.sv @@
// datapath: shared multiplier, loop state and result register
`default_nettype none

module pidfd_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  pidfd_pkg::cfg_type              cfg,
   input  pidfd_pkg::cmd_type              cmd,
   input  logic signed [pidfd_pkg::DATA_W-1:0] req_error,
   output logic signed [pidfd_pkg::DATA_W-1:0] drive,
   output logic signed [pidfd_pkg::DATA_W-1:0] p_term,
   output logic signed [pidfd_pkg::DATA_W-1:0] i_term,
   output logic signed [pidfd_pkg::DATA_W-1:0] d_term
);
   import pidfd_pkg::*;

   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + DATA_W;
   localparam int INC_SH = FRAC_W + DT_FRAC;
   localparam logic signed [DATA_W-1:0] DW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [ACC_W-1:0] wide_type;

   // saturate a wide signed value to the data range
   function automatic logic signed [DATA_W-1:0] sat_dw(input wide_type v);
      logic [ACC_W-DATA_W:0] upper;
      upper = v[ACC_W-1:DATA_W-1];
      if ((&upper) || !(|upper)) begin
         sat_dw = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat_dw = DW_MIN;
      end else begin
         sat_dw = DW_MAX;
      end
   endfunction

   logic signed [DATA_W-1:0] e_ff, e_in;
   logic signed [MUL_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [DATA_W-1:0] kie_hi_ff, kie_hi_in;
   logic [DATA_W-1:0]        kie_lo_ff, kie_lo_in;
   logic signed [MUL_W-1:0]  rdiff_ff, rdiff_in;
   wide_type                 acc_ff, acc_in;
   logic signed [DATA_W-1:0] inc_ff, inc_in;
   logic signed [DATA_W-1:0] fd_ff, fd_in;
   logic signed [DATA_W-1:0] last_e_ff, last_e_in;
   logic signed [DATA_W-1:0] int_ff, int_in;
   logic signed [DATA_W-1:0] p_ff, p_in;
   logic signed [DATA_W-1:0] dterm_ff, dterm_in;
   logic signed [DATA_W-1:0] out_drive_ff, out_drive_in;
   logic signed [DATA_W-1:0] out_p_ff, out_p_in;
   logic signed [DATA_W-1:0] out_i_ff, out_i_in;
   logic signed [DATA_W-1:0] out_d_ff, out_d_in;

   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [DATA_W-1:0] prod_q;
   logic signed [DATA_W:0]   int_sum;
   logic signed [DATA_W:0]   lim_pos;
   logic signed [DATA_W:0]   lim_neg;

   // multiplier operand selection
   always_comb begin
      case (cmd.mul_sel)
         MUL_KIE: begin
            mul_a = MUL_W'($signed(cfg.ki));
            mul_b = MUL_W'(e_ff);
         end
         MUL_RAW: begin
            mul_a = diff_ff;
            mul_b = $signed({1'b0, cfg.inv_dt});
         end
         MUL_IHI: begin
            mul_a = MUL_W'(kie_hi_ff);
            mul_b = $signed(MUL_W'(cfg.dt));
         end
         MUL_FILT: begin
            mul_a = rdiff_ff;
            mul_b = $signed(MUL_W'(cfg.d_alpha));
         end
         MUL_ILO: begin
            mul_a = $signed({1'b0, kie_lo_ff});
            mul_b = $signed(MUL_W'(cfg.dt));
         end
         MUL_KD: begin
            mul_a = MUL_W'($signed(cfg.kd));
            mul_b = MUL_W'(fd_ff);
         end
         MUL_KP: begin
            mul_a = MUL_W'($signed(cfg.kp));
            mul_b = MUL_W'(e_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // q16.16 product scaled back and saturated
   assign prod_q = sat_dw(wide_type'(mul_ff) >>> FRAC_W);

   // integrator clamp bounds
   assign int_sum = (DATA_W+1)'(int_ff) + (DATA_W+1)'(inc_ff);
   assign lim_pos = $signed({2'b00, cfg.i_limit});
   assign lim_neg = -lim_pos;

   // next values of the datapath registers
   always_comb begin
      e_in         = e_ff;
      diff_in      = diff_ff;
      mul_in       = mul_ff;
      kie_hi_in    = kie_hi_ff;
      kie_lo_in    = kie_lo_ff;
      rdiff_in     = rdiff_ff;
      acc_in       = acc_ff;
      inc_in       = inc_ff;
      fd_in        = fd_ff;
      last_e_in    = last_e_ff;
      int_in       = int_ff;
      p_in         = p_ff;
      dterm_in     = dterm_ff;
      out_drive_in = out_drive_ff;
      out_p_in     = out_p_ff;
      out_i_in     = out_i_ff;
      out_d_in     = out_d_ff;

      // new error sample and its difference to the last one
      if (cmd.load) begin
         e_in    = req_error;
         diff_in = MUL_W'(req_error) - MUL_W'(last_e_ff);
      end

      // shared multiplier
      if (cmd.mul_sel != MUL_NONE) begin
         mul_in = mul_a * mul_b;
      end

      // product post-processing
      case (cmd.post_sel)
         POST_KIE: begin
            kie_hi_in = mul_ff[2*DATA_W-1:DATA_W];
            kie_lo_in = mul_ff[DATA_W-1:0];
         end
         POST_RDIFF: begin
            rdiff_in = MUL_W'(prod_q) - MUL_W'(fd_ff);
         end
         POST_ACC_HI: begin
            acc_in = wide_type'(mul_ff) <<< DATA_W;
         end
         POST_FILT: begin
            fd_in     = sat_dw(wide_type'(fd_ff) + wide_type'(prod_q));
            last_e_in = e_ff;
         end
         POST_ACC_LO: begin
            acc_in = acc_ff + wide_type'(mul_ff);
         end
         POST_DT_INC: begin
            dterm_in = prod_q;
            inc_in   = sat_dw(acc_ff >>> INC_SH);
         end
         POST_PI: begin
            p_in = prod_q;
            if (int_sum > lim_pos) begin
               int_in = DATA_W'(lim_pos);
            end else if (int_sum < lim_neg) begin
               int_in = DATA_W'(lim_neg);
            end else begin
               int_in = DATA_W'(int_sum);
            end
         end
         default: begin
         end
      endcase

      // clear zeroes the loop state and the terms
      if (cmd.clear) begin
         fd_in     = '0;
         last_e_in = '0;
         int_in    = '0;
         p_in      = '0;
         dterm_in  = '0;
      end

      // result register
      if (cmd.out_load) begin
         out_drive_in = sat_dw(wide_type'(p_ff) + wide_type'(int_ff) + wide_type'(dterm_ff));
         out_p_in     = p_ff;
         out_i_in     = int_ff;
         out_d_in     = dterm_ff;
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff     <= '0;
         last_e_ff <= '0;
         int_ff    <= '0;
      end else begin
         fd_ff     <= fd_in;
         last_e_ff <= last_e_in;
         int_ff    <= int_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      e_ff         <= e_in;
      diff_ff      <= diff_in;
      mul_ff       <= mul_in;
      kie_hi_ff    <= kie_hi_in;
      kie_lo_ff    <= kie_lo_in;
      rdiff_ff     <= rdiff_in;
      acc_ff       <= acc_in;
      inc_ff       <= inc_in;
      p_ff         <= p_in;
      dterm_ff     <= dterm_in;
      out_drive_ff <= out_drive_in;
      out_p_ff     <= out_p_in;
      out_i_ff     <= out_i_in;
      out_d_ff     <= out_d_in;
   end

   assign drive  = out_drive_ff;
   assign p_term = out_p_ff;
   assign i_term = out_i_ff;
   assign d_term = out_d_ff;

endmodule

`default_nettype wire

@@ rtl/pid_with_filtered_derivative.sv @@
// top level of the pid controller with clamped integrator and filtered derivative
//
// One update request returns one response: drive = sat(P + I + D) with the three
// terms, all signed Q16.16. The seven products of an update (ki*e, two halves of
// (ki*e)*dt, the raw derivative, the filter step, kd*d and kp*e) go one per cycle
// through a single 33x33 signed multiplier. The output register takes the
// response in the S_OUT state once it is free, and a new request is taken only
// when the sequencer is back in idle. A clear request zeroes integrator, last
// error and filter state and returns an all-zero response through S_OUT. The
// output register lets the next request in while a response waits. Register
// writes are taken at any time but belong in idle periods.
`default_nettype none

module pid_with_filtered_derivative (
   input  logic        clock,
   input  logic        reset,
   pidfd_req_if.sink   req_ch,
   pidfd_rsp_if.source rsp_ch,
   pidfd_csr_if.sink   csr_ch
);
   import pidfd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;

   // register file
   pidfd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // sequencer
   pidfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // arithmetic and state
   pidfd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_error (req_ch.error_in),
      .drive     (rsp_ch.drive),
      .p_term    (rsp_ch.p_term),
      .i_term    (rsp_ch.i_term),
      .d_term    (rsp_ch.d_term)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

`default_nettype wire

@@ rtl/pidfd_checker.sv @@
// port-level checks of the pid controller and their binding
`default_nettype none

module pidfd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [pidfd_pkg::DATA_W-1:0]  drive,
   input logic signed [pidfd_pkg::DATA_W-1:0]  p_term,
   input logic signed [pidfd_pkg::DATA_W-1:0]  i_term,
   input logic signed [pidfd_pkg::DATA_W-1:0]  d_term
);
   import pidfd_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      count_in = count_ff;
      if (req_take && !rsp_take) begin
         count_in = count_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(drive) && $stable(p_term)
         && $stable(i_term) && $stable(d_term))
      else $error("response payload changed while stalled");

   // every response answers a request, and at most two are in flight
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 2'd0)
      else $error("response without an open request");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("request count out of range");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind pid_with_filtered_derivative pidfd_checker u_pidfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .drive     (rsp_ch.drive),
   .p_term    (rsp_ch.p_term),
   .i_term    (rsp_ch.i_term),
   .d_term    (rsp_ch.d_term)
);

`default_nettype wire
